FILE: src/jscs_pkg.sv
// Shared types and constants for the JavaScript comment stripper.
package jscs_pkg;

    // Scan modes of the lexer.
    localparam logic [2:0] MODE_CODE   = 3'd0;
    localparam logic [2:0] MODE_SQUOTE = 3'd1;
    localparam logic [2:0] MODE_DQUOTE = 3'd2;
    localparam logic [2:0] MODE_REGEX  = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;
    localparam logic [2:0] MODE_LINE   = 3'd5;
    localparam logic [2:0] MODE_COND   = 3'd6;

    // Characters the lexer looks for.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Most result words that one input word can cause.
    localparam int MAX_WORDS = 4;

    // Lexer state that travels from one decision to the next.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] h2;
        logic [7:0] h1;
        logic       skip;
    } t_scan;

    // One queue entry: the result words caused by one input word.
    typedef struct packed {
        logic [MAX_WORDS-1:0][7:0] bytes;
        logic [1:0]                cnt_m1;
        logic                      bare;
        logic                      last;
    } t_entry;

endpackage

FILE: src/js_comment_stripper.sv
// JavaScript comment stripper top level: removes block and line comments.
// A byte is decided when the word two behind it arrives; its result words are
// queued on that acceptance. Throughput: one input word per cycle while the
// queue has room; the final word of a text produces up to four output words,
// drained one per cycle from the entry queue while the receiver is ready.
// Reset: i_rst_n is synchronous, active low, and clears lexer state and queue.
module js_comment_stripper #(
    parameter int QUEUE_DEPTH = jscs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [1:0] m_tuser    // [0] byte_valid, [1] stream_end
);
    import jscs_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry entry;
    t_entry head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    jscs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_push   (push),
        .o_entry  (entry)
    );

    jscs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    jscs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

endmodule

FILE: src/jscs_front.sv
// Front part: accepts source words, runs the lexer and builds queue entries.
module jscs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_push,
    output jscs_pkg::t_entry o_entry
);
    import jscs_pkg::*;

    typedef struct packed {
        t_scan s;
        logic  keep;
    } t_dec;

    // One lexer decision for the byte cur, with the two bytes that follow it.
    function automatic t_dec decide(input t_scan s, input logic [7:0] cur,
                                    input logic [7:0] n1, input logic [7:0] n2);
        t_dec d;
        d.s    = s;
        d.keep = 1'b0;
        if (s.skip) begin
            d.s.skip = 1'b0;
        end else begin
            case (s.mode)
                MODE_REGEX: begin
                    if (cur == CH_SLASH && s.h1 != CH_SLASH) d.s.mode = MODE_CODE;
                    d.keep = 1'b1;
                end
                MODE_SQUOTE: begin
                    if (cur == CH_SQUOTE && s.h1 != CH_BSLASH) d.s.mode = MODE_CODE;
                    d.keep = 1'b1;
                end
                MODE_DQUOTE: begin
                    if (cur == CH_DQUOTE && s.h1 != CH_BSLASH) d.s.mode = MODE_CODE;
                    d.keep = 1'b1;
                end
                MODE_BLOCK: begin
                    if (cur == CH_STAR && n1 == CH_SLASH) begin
                        d.s.mode = MODE_CODE;
                        d.s.skip = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (n1 == CH_LF || n1 == CH_CR) d.s.mode = MODE_CODE;
                end
                MODE_COND: begin
                    if (s.h2 == CH_AT && s.h1 == CH_STAR && cur == CH_SLASH) begin
                        d.s.mode = MODE_CODE;
                    end
                    d.keep = 1'b1;
                end
                default: begin
                    d.keep = 1'b1;
                    if (cur == CH_DQUOTE) d.s.mode = MODE_DQUOTE;
                    if (cur == CH_SQUOTE) d.s.mode = MODE_SQUOTE;
                    if (cur == CH_SLASH) begin
                        if (n1 == CH_STAR) begin
                            if (n2 == CH_AT) begin
                                d.s.mode = MODE_COND;
                            end else begin
                                d.s.mode = MODE_BLOCK;
                                d.keep   = 1'b0;
                            end
                        end else if (n1 == CH_SLASH) begin
                            d.s.mode = MODE_LINE;
                            d.keep   = 1'b0;
                        end else begin
                            d.s.mode = MODE_REGEX;
                        end
                    end
                end
            endcase
        end
        d.s.h2 = s.h1;
        d.s.h1 = cur;
        return d;
    endfunction

    t_scan      r_scan, n_scan;
    logic [1:0] r_pend, n_pend;
    logic [7:0] r_w2, n_w2;
    logic [7:0] r_w3, n_w3;
    logic [7:0] r_last_emit, n_last_emit;
    logic       r_any, n_any;

    logic [4:0][7:0]           p;
    logic [1:0]                npn;
    logic [2:0]                cnt;
    logic [MAX_WORDS-1:0][7:0] obytes;
    t_dec                      d;
    logic                      do_dec;

    // Gather the bytes awaiting a decision, then run up to three decisions.
    always_comb begin
        p      = '0;
        p[0]   = (r_pend != 2'd0) ? r_w2 : i_byte;
        p[1]   = (r_pend == 2'd2) ? r_w3 : ((r_pend == 2'd1) ? i_byte : 8'd0);
        p[2]   = (r_pend == 2'd2) ? i_byte : 8'd0;
        npn    = r_pend + 2'd1;
        n_scan      = r_scan;
        n_last_emit = r_last_emit;
        n_any       = r_any;
        cnt    = '0;
        obytes = '0;
        d      = '0;
        do_dec = 1'b0;
        for (int i = 0; i < 3; i++) begin
            do_dec = i_last ? (2'(i) < npn) : (i == 0 && npn == 2'd3);
            if (do_dec) begin
                d      = decide(n_scan, p[i], p[i+1], p[i+2]);
                n_scan = d.s;
                if (d.keep) begin
                    obytes[cnt[1:0]] = p[i];
                    cnt              = cnt + 3'd1;
                    n_last_emit      = p[i];
                    n_any            = 1'b1;
                end
            end
        end
        // A text with kept output that does not end in a newline gets one.
        if (i_last && i_byte != CH_LF && n_any && n_last_emit != CH_LF) begin
            obytes[cnt[1:0]] = CH_LF;
            cnt              = cnt + 3'd1;
        end
        n_w2   = (npn == 2'd3) ? p[1] : p[0];
        n_w3   = (npn == 2'd3) ? p[2] : p[1];
        n_pend = (npn == 2'd3) ? 2'd2 : npn;
    end

    // Build the queue entry for this input word.
    always_comb begin
        o_entry.bytes  = obytes;
        o_entry.bare   = i_last && (cnt == 3'd0);
        o_entry.cnt_m1 = (cnt == 3'd0) ? 2'd0 : 2'(cnt - 3'd1);
        o_entry.last   = i_last;
        o_push         = i_accept && (i_last || cnt != 3'd0);
    end

    // Lexer state; the final word of a text returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_scan      <= '0;
            r_pend      <= '0;
            r_w2        <= '0;
            r_w3        <= '0;
            r_last_emit <= '0;
            r_any       <= 1'b0;
        end else if (i_accept) begin
            r_scan      <= n_scan;
            r_pend      <= n_pend;
            r_w2        <= n_w2;
            r_w3        <= n_w3;
            r_last_emit <= n_last_emit;
            r_any       <= n_any;
        end
    end

endmodule

FILE: src/jscs_queue.sv
// Short queue of result entries between the front and back parts.
module jscs_queue #(
    parameter int DEPTH = jscs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jscs_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output jscs_pkg::t_entry o_head
);
    import jscs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: src/jscs_back.sv
// Back part: sends the words of each queue entry out one at a time.
module jscs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  jscs_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tlast,
    output logic [1:0]      o_m_tuser
);
    import jscs_pkg::*;

    logic [1:0] r_sub;
    logic       at_end;
    logic       fire;

    assign at_end     = (r_sub == i_head.cnt_m1);
    assign fire       = o_m_tvalid && i_m_tready;
    assign o_pop      = fire && at_end;
    assign o_m_tvalid = !i_empty;
    assign o_m_tdata  = i_head.bytes[r_sub];
    assign o_m_tlast  = at_end;
    assign o_m_tuser  = {i_head.last && at_end, !i_head.bare};

    // Word index within the head entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (fire) begin
            r_sub <= at_end ? 2'd0 : r_sub + 2'd1;
        end
    end

endmodule

FILE: tb/jscs_checker.sv
// Checker for the comment stripper: predicts the output stream and compares it word by word.
module jscs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,   // run_last
    input  logic [1:0] m_tuser,   // [0] byte_valid, [1] stream_end
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jscs_pkg::*;

    // One predicted output word.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       text_end;
    } t_out_word;

    t_out_word expected_words[$];
    t_out_word step_words[$];
    int        mismatch_cnt = 0;

    // Lexer state of the prediction.
    logic [2:0] lex_mode;
    logic [7:0] hist2, hist1;
    logic [7:0] held_a, held_b;
    int         held_cnt;
    logic       skip_close;
    logic [7:0] prev_out;
    logic       out_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic reset_lexer();
        lex_mode   = MODE_CODE;
        hist2      = 8'h00;
        hist1      = 8'h00;
        held_a     = 8'h00;
        held_b     = 8'h00;
        held_cnt   = 0;
        skip_close = 1'b0;
        prev_out   = 8'h00;
        out_seen   = 1'b0;
    endtask

    task automatic keep_byte(input logic [7:0] b);
        step_words.push_back({b, 1'b1, 1'b0, 1'b0});
        prev_out = b;
        out_seen = 1'b1;
    endtask

    // Decide one byte from the two bytes behind it and the two bytes ahead.
    task automatic decide_byte(input logic [7:0] cur, input logic [7:0] n1,
                               input logic [7:0] n2);
        logic keep;
        keep = 1'b0;
        if (skip_close) begin
            // This is the slash that closes a block comment.
            skip_close = 1'b0;
        end else begin
            case (lex_mode)
                MODE_REGEX: begin
                    if (cur == CH_SLASH && hist1 != CH_SLASH) lex_mode = MODE_CODE;
                    keep = 1'b1;
                end
                MODE_SQUOTE: begin
                    if (cur == CH_SQUOTE && hist1 != CH_BSLASH) lex_mode = MODE_CODE;
                    keep = 1'b1;
                end
                MODE_DQUOTE: begin
                    if (cur == CH_DQUOTE && hist1 != CH_BSLASH) lex_mode = MODE_CODE;
                    keep = 1'b1;
                end
                MODE_BLOCK: begin
                    if (cur == CH_STAR && n1 == CH_SLASH) begin
                        lex_mode   = MODE_CODE;
                        skip_close = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (n1 == CH_LF || n1 == CH_CR) lex_mode = MODE_CODE;
                end
                MODE_COND: begin
                    if (hist2 == CH_AT && hist1 == CH_STAR && cur == CH_SLASH)
                        lex_mode = MODE_CODE;
                    keep = 1'b1;
                end
                default: begin
                    keep = 1'b1;
                    if (cur == CH_DQUOTE) lex_mode = MODE_DQUOTE;
                    if (cur == CH_SQUOTE) lex_mode = MODE_SQUOTE;
                    if (cur == CH_SLASH) begin
                        if (n1 == CH_STAR) begin
                            if (n2 == CH_AT) begin
                                lex_mode = MODE_COND;
                            end else begin
                                lex_mode = MODE_BLOCK;
                                keep     = 1'b0;
                            end
                        end else if (n1 == CH_SLASH) begin
                            lex_mode = MODE_LINE;
                            keep     = 1'b0;
                        end else begin
                            lex_mode = MODE_REGEX;
                        end
                    end
                end
            endcase
        end
        if (keep) keep_byte(cur);
        hist2 = hist1;
        hist1 = cur;
    endtask

    // Work out the output words that one accepted input word causes.
    task automatic predict_stripped(input logic [7:0] b, input logic is_final);
        logic [7:0] pend[3];
        logic [7:0] n1, n2;
        int         np;
        step_words.delete();
        np      = held_cnt;
        pend[0] = held_a;
        pend[1] = held_b;
        pend[2] = 8'h00;
        pend[np] = b;
        np++;
        if (!is_final) begin
            if (np == 3) begin
                decide_byte(pend[0], pend[1], pend[2]);
                pend[0] = pend[1];
                pend[1] = pend[2];
                np = 2;
            end
            held_cnt = np;
            held_a   = pend[0];
            held_b   = pend[1];
            if (step_words.size() > 0) step_words[step_words.size()-1].run_end = 1'b1;
        end else begin
            // Flush the pending bytes; bytes past the end read as zero.
            for (int i = 0; i < np; i++) begin
                n1 = (i + 1 < np) ? pend[i+1] : 8'h00;
                n2 = (i + 2 < np) ? pend[i+2] : 8'h00;
                decide_byte(pend[i], n1, n2);
            end
            if (b != CH_LF && out_seen && prev_out != CH_LF) keep_byte(CH_LF);
            // An empty final step still sends a bare end marker.
            if (step_words.size() == 0) step_words.push_back({8'h00, 1'b0, 1'b0, 1'b0});
            step_words[step_words.size()-1].run_end  = 1'b1;
            step_words[step_words.size()-1].text_end = 1'b1;
            reset_lexer();
        end
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endtask

    // Predict on accepted input words, compare on accepted output words.
    always @(posedge i_clk) begin
        t_out_word w;
        if (!i_rst_n) begin
            reset_lexer();
            expected_words.delete();
        end else begin
            if (s_tvalid && s_tready) predict_stripped(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected output word: out_byte %h", m_tdata);
                    mismatch_cnt++;
                end else begin
                    w = expected_words.pop_front();
                    if (m_tdata != w.data) begin
                        $error("out_byte: expected %h, actual %h", w.data, m_tdata);
                        mismatch_cnt++;
                    end
                    if (m_tuser[0] != w.has_byte) begin
                        $error("byte_valid: expected %b, actual %b", w.has_byte, m_tuser[0]);
                        mismatch_cnt++;
                    end
                    if (m_tlast != w.run_end) begin
                        $error("run_last: expected %b, actual %b", w.run_end, m_tlast);
                        mismatch_cnt++;
                    end
                    if (m_tuser[1] != w.text_end) begin
                        $error("stream_end: expected %b, actual %b", w.text_end, m_tuser[1]);
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= expected_words.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the comment stripper: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jscs_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 200;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;
    int         fail_count;
    int         pending_words;

    logic [7:0] src_text[$];
    int         words_sent  = 0;
    int         burst_left  = 0;
    int         cycle_cnt   = 0;

    js_comment_stripper uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    jscs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // Free-running clock, 8 ns period.
    always #4 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall phases, plus one long hold-off to fill the block.
    initial begin
        int hold_left;
        int phase;
        int phase_left;
        bit held;
        hold_left  = 0;
        phase      = 0;
        phase_left = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!held && words_sent >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase      = $urandom_range(0, 3);
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                case (phase)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ((phase_left % 3) == 0);
                endcase
            end
        end
    end

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
    endtask

    // Character for the inside of strings, regexes and comments.
    function automatic logic [7:0] body_char();
        case ($urandom_range(0, 9))
            6:       return 8'h20;
            7:       return CH_STAR;
            8:       return CH_AT;
            9:       return CH_BSLASH;
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic add_body(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) src_text.push_back(body_char());
    endtask

    // Build a random text, mostly well-formed tokens with some noise.
    task automatic build_random_text();
        int pieces;
        src_text.delete();
        if ($urandom_range(0, 7) == 0) begin
            // Very short texts exercise the start and end of text together.
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 2))
                    0:       src_text.push_back(CH_SLASH);
                    1:       src_text.push_back(CH_STAR);
                    default: src_text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            case ($urandom_range(0, 11))
                0: repeat ($urandom_range(1, 3)) src_text.push_back(8'($urandom_range(0, 255)));
                1, 10: repeat ($urandom_range(1, 4))
                    src_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
                2: begin
                    src_text.push_back(CH_SQUOTE);
                    add_body(0, 4);
                    if ($urandom_range(0, 1)) begin
                        src_text.push_back(CH_BSLASH);
                        src_text.push_back(CH_SQUOTE);
                    end
                    src_text.push_back(CH_SQUOTE);
                end
                3: begin
                    src_text.push_back(CH_DQUOTE);
                    add_body(0, 4);
                    if ($urandom_range(0, 1)) begin
                        src_text.push_back(CH_BSLASH);
                        src_text.push_back(CH_DQUOTE);
                    end
                    src_text.push_back(CH_DQUOTE);
                end
                4: begin
                    src_text.push_back(CH_SLASH);
                    add_body(1, 4);
                    src_text.push_back(CH_SLASH);
                end
                5: begin
                    push_str("/*");
                    add_body(0, 5);
                    push_str("*/");
                end
                6: begin
                    push_str("//");
                    add_body(0, 5);
                    src_text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
                end
                7: begin
                    push_str("/*@");
                    add_body(0, 4);
                    push_str("@*/");
                end
                8: begin
                    case ($urandom_range(0, 2))
                        0:       src_text.push_back(CH_LF);
                        1:       src_text.push_back(CH_CR);
                        default: src_text.push_back(8'h20);
                    endcase
                end
                9: begin
                    case ($urandom_range(0, 3))
                        0:       src_text.push_back(CH_SLASH);
                        1:       src_text.push_back(CH_STAR);
                        2:       src_text.push_back(CH_AT);
                        default: src_text.push_back(8'h3B);
                    endcase
                end
                default: push_str("\"a\\\"b\"");
            endcase
        end
    endtask

    // Send the text in bursts with random gaps, tlast on its final word.
    task automatic send_text();
        int gap;
        for (int i = 0; i < src_text.size(); i++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= src_text[i];
            s_tlast  <= (i == src_text.size() - 1);
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
            burst_left--;
            words_sent++;
        end
    endtask

    // Reset, directed texts, random texts, drain and verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Line and block comment openers alone give empty output.
        src_text.delete(); push_str("//"); send_text();
        src_text.delete(); push_str("/*"); send_text();
        // A single top-value byte, then a lone newline.
        src_text.delete(); src_text.push_back(8'hFF); send_text();
        src_text.delete(); src_text.push_back(CH_LF); send_text();
        // A conditional-compilation block passes through.
        src_text.delete(); push_str("/*@a@*/"); send_text();
        // An escaped quote inside a single-quote string.
        src_text.delete(); push_str("'\\''"); send_text();
        // A line comment keeps its newline.
        src_text.delete(); push_str("x//c\n"); send_text();
        // A zero byte is an ordinary byte.
        src_text.delete(); src_text.push_back(8'h00); src_text.push_back(8'h62); send_text();

        while (words_sent < RANDOM_ITEMS + 24) begin
            build_random_text();
            send_text();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
src/jscs_pkg.sv
src/jscs_front.sv
src/jscs_queue.sv
src/jscs_back.sv
src/js_comment_stripper.sv
tb/jscs_checker.sv
tb/tb_top.sv
